/* design/ocsr_pkg.sv */
// Shared types and constants for the octree cell symbol ranker.
package ocsr_pkg;

    localparam int NUM_AXES   = 3;
    localparam int NUM_CELLS  = 8;
    localparam int CELL_BITS  = 3;
    localparam int LEVEL_BITS = 6;
    localparam int CFG_BITS   = 5;
    localparam int CFG_IDX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUANT_BITS   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CUR_QUANT_ID = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COMPRESS     = 2'd2;

    // square root unit control and status
    typedef struct packed {
        logic start;
    } t_sqrt_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_stat;

endpackage

/* design/ocsr_isqrt.sv */
// Digit-serial integer square root, one radicand bit pair per cycle.
module ocsr_isqrt #(
    parameter int ROOT_BITS = 21
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ocsr_pkg::t_sqrt_req         i_req,
    input  logic [2*ROOT_BITS-1:0]      i_radicand,
    output ocsr_pkg::t_sqrt_stat        o_stat,
    output logic [ROOT_BITS-1:0]        o_root
);
    import ocsr_pkg::*;

    localparam int IN_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS = ROOT_BITS + 2;
    localparam int CNT_BITS = $clog2(ROOT_BITS + 1);

    logic [IN_BITS-1:0]   r_rad, n_rad;
    logic [REM_BITS-1:0]  r_rem, n_rem;
    logic [ROOT_BITS-1:0] r_root, n_root;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic                 r_done, n_done;

    logic [REM_BITS+1:0]  rem_shift;
    logic [REM_BITS+1:0]  trial;
    logic [REM_BITS+1:0]  diff;

    assign rem_shift = {r_rem, r_rad[IN_BITS-1 -: 2]};
    assign trial     = (REM_BITS+2)'({r_root, 2'b01});
    assign diff      = rem_shift - trial;

    always_comb begin
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rad  = i_radicand;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = CNT_BITS'(ROOT_BITS);
        end else if (r_cnt != '0) begin
            n_rad = r_rad << 2;
            if (rem_shift >= trial) begin
                n_rem  = diff[REM_BITS-1:0];
                n_root = {r_root[ROOT_BITS-2:0], 1'b1};
            end else begin
                n_rem  = rem_shift[REM_BITS-1:0];
                n_root = {r_root[ROOT_BITS-2:0], 1'b0};
            end
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_BITS'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_root      = r_root;

endmodule

/* design/octree_cell_symbol_ranker.sv */
// Top level of the octree cell symbol ranker.
//
//  channel | direction | handshake               | payload
//  cfg     | in        | i_cfg_we                | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid / o_in_stall | center, nb, old coords, flags
//  out     | out       | o_out_valid / i_out_stall | map_key, map_value, last_pair
//
// One request at a time. A neighbour is squared axis by axis, waits for the digit-serial
// root unit to finish, then takes a multiply and an accumulate step; a new request is
// taken only in idle, after the accumulate step. The last neighbour adds unbalance,
// weighting, priority and ranking, then 8 output pairs at one per cycle while not stalled.
// Reset is synchronous active low; it clears the side sums and control state and restores the config defaults.
// A stalled output pair holds; the input side stays stalled until the run's pairs are gone.
module octree_cell_symbol_ranker #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 4,
    parameter int SUM_BITS   = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ocsr_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [ocsr_pkg::CFG_BITS-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [COORD_BITS-1:0]      i_center_x,
    input  logic signed [COORD_BITS-1:0]      i_center_y,
    input  logic signed [COORD_BITS-1:0]      i_center_z,
    input  logic signed [COORD_BITS-1:0]      i_nb_x,
    input  logic signed [COORD_BITS-1:0]      i_nb_y,
    input  logic signed [COORD_BITS-1:0]      i_nb_z,
    input  logic signed [COORD_BITS-1:0]      i_old_x,
    input  logic signed [COORD_BITS-1:0]      i_old_y,
    input  logic signed [COORD_BITS-1:0]      i_old_z,
    input  logic                              i_conquered,
    input  logic                              i_last_neighbour,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ocsr_pkg::CELL_BITS-1:0]    o_map_key,
    output logic [ocsr_pkg::CELL_BITS-1:0]    o_map_value,
    output logic                              o_last_pair
);
    import ocsr_pkg::*;

    localparam int ABS_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS   = 2 * COORD_BITS + 2;
    localparam int ROOT_BITS = COORD_BITS + 1 + FRAC_BITS;
    localparam int W_BITS    = ROOT_BITS + LEVEL_BITS;
    localparam int ADD_BITS  = (SUM_BITS > W_BITS ? SUM_BITS : W_BITS) + 1;
    localparam int PRIO_BITS = SUM_BITS + 4;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQ   = 4'd1;
    localparam logic [3:0] S_ROOT = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_ACC  = 4'd4;
    localparam logic [3:0] S_UNB  = 4'd5;
    localparam logic [3:0] S_WGT  = 4'd6;
    localparam logic [3:0] S_PRIO = 4'd7;
    localparam logic [3:0] S_RANK = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    localparam logic [ADD_BITS-1:0] SUM_MAX = ADD_BITS'({SUM_BITS{1'b1}});

    // config
    logic [CFG_BITS-1:0] r_quant_bits, r_cur_quant_id;
    logic                r_compress;

    logic [3:0]            r_state, n_state;
    logic [CELL_BITS-1:0]  r_cnt, n_cnt;

    // per-neighbour working registers
    logic [ABS_BITS-1:0]   r_abs  [NUM_AXES];
    logic                  r_side [NUM_AXES];
    logic [LEVEL_BITS-1:0] r_level;
    logic                  r_last;
    logic [SQ_BITS-1:0]    r_sq;
    logic [W_BITS-1:0]     r_w;

    logic [SUM_BITS-1:0]   r_lo [NUM_AXES];
    logic [SUM_BITS-1:0]   r_hi [NUM_AXES];
    logic [SUM_BITS-1:0]   r_unb [NUM_AXES];
    logic [1:0]            r_wgt [NUM_AXES];
    logic [PRIO_BITS-1:0]  r_prio [NUM_CELLS];
    logic [CELL_BITS-1:0]  r_pid  [NUM_CELLS];
    logic [CELL_BITS-1:0]  r_sym  [NUM_CELLS];
    logic [CELL_BITS-1:0]  r_cell [NUM_CELLS];

    // root unit
    t_sqrt_req             sq_req;
    t_sqrt_stat            sq_stat;
    logic [ROOT_BITS-1:0]  sq_root;
    logic [2*ROOT_BITS-1:0] radicand;

    logic                  in_acc, out_acc;
    logic [ABS_BITS-1:0]   d_abs  [NUM_AXES];
    logic                  d_low  [NUM_AXES];
    logic [CFG_BITS-1:0]   lvl_base;
    logic [2*ABS_BITS-1:0] prod;
    logic [SQ_BITS-1:0]    sq_next;
    logic [PRIO_BITS-1:0]  cell_prio;
    logic [CELL_BITS-1:0]  rank;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // deltas at accept: conquered neighbours use the old position when compressing
    always_comb begin
        logic signed [COORD_BITS-1:0] ctr [NUM_AXES];
        logic signed [COORD_BITS-1:0] pos [NUM_AXES];
        logic signed [ABS_BITS-1:0]   d;
        ctr[0] = i_center_x; ctr[1] = i_center_y; ctr[2] = i_center_z;
        if (i_conquered && r_compress) begin
            pos[0] = i_old_x; pos[1] = i_old_y; pos[2] = i_old_z;
        end else begin
            pos[0] = i_nb_x; pos[1] = i_nb_y; pos[2] = i_nb_z;
        end
        for (int j = 0; j < NUM_AXES; j++) begin
            d = ABS_BITS'(pos[j]) - ABS_BITS'(ctr[j]);
            d_abs[j] = d[ABS_BITS-1] ? ABS_BITS'(-d) : ABS_BITS'(d);
            d_low[j] = d[ABS_BITS-1] || (d == '0);
        end
    end

    assign lvl_base = (r_quant_bits > r_cur_quant_id) ? r_quant_bits - r_cur_quant_id : '0;

    assign prod     = r_abs[r_cnt[1:0]] * r_abs[r_cnt[1:0]];
    // running sum including this cycle's axis, so the root starts on all three
    assign sq_next  = (r_cnt == '0) ? SQ_BITS'(prod) : r_sq + SQ_BITS'(prod);
    assign radicand = (2*ROOT_BITS)'(sq_next) << (2 * FRAC_BITS);
    assign sq_req.start = (r_state == S_SQ) && (r_cnt == CELL_BITS'(NUM_AXES - 1));

    ocsr_isqrt #(.ROOT_BITS(ROOT_BITS)) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (sq_req),
        .i_radicand (radicand),
        .o_stat     (sq_stat),
        .o_root     (sq_root)
    );

    // priority of cell r_cnt: weighted sum of the side each axis bit picks
    always_comb begin
        logic [SUM_BITS-1:0] s;
        cell_prio = '0;
        for (int j = 0; j < NUM_AXES; j++) begin
            s = r_cnt[j] ? r_hi[j] : r_lo[j];
            cell_prio = cell_prio
                      + (r_wgt[j][0] ? PRIO_BITS'(s) : '0)
                      + (r_wgt[j][1] ? PRIO_BITS'(s) << 1 : '0);
        end
    end

    // rank of the head entry; ties go to the lower cell
    always_comb begin
        rank = '0;
        for (int i = 1; i < NUM_CELLS; i++) begin
            if (r_prio[i] < r_prio[0] || (r_prio[i] == r_prio[0] && r_pid[i] < r_pid[0]))
                rank = rank + 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SQ;
                    n_cnt   = '0;
                end
            end
            S_SQ: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CELL_BITS'(NUM_AXES - 1))
                    n_state = S_ROOT;
            end
            S_ROOT: begin
                if (sq_stat.done)
                    n_state = S_MUL;
            end
            S_MUL:  n_state = S_ACC;
            S_ACC:  n_state = r_last ? S_UNB : S_IDLE;
            S_UNB:  n_state = S_WGT;
            S_WGT: begin
                n_state = S_PRIO;
                n_cnt   = '0;
            end
            S_PRIO: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CELL_BITS'(NUM_CELLS - 1))
                    n_state = S_RANK;
            end
            S_RANK: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CELL_BITS'(NUM_CELLS - 1))
                    n_state = S_OUT;
            end
            S_OUT: begin
                if (out_acc) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == CELL_BITS'(NUM_CELLS - 1))
                        n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int j = 0; j < NUM_AXES; j++) begin
                r_abs[j]  <= d_abs[j];
                r_side[j] <= !d_low[j];
            end
            r_level <= LEVEL_BITS'(lvl_base) + LEVEL_BITS'(i_conquered);
            r_last  <= i_last_neighbour;
        end
        if (r_state == S_SQ)
            r_sq <= sq_next;
        if (r_state == S_MUL)
            r_w <= W_BITS'(r_level) * W_BITS'(sq_root);
        if (r_state == S_UNB) begin
            for (int j = 0; j < NUM_AXES; j++)
                r_unb[j] <= (r_lo[j] >= r_hi[j]) ? r_lo[j] - r_hi[j] : r_hi[j] - r_lo[j];
        end
        if (r_state == S_WGT) begin
            for (int j = 0; j < NUM_AXES; j++) begin
                logic [1:0] w;
                w = 2'd0;
                for (int k = 0; k < NUM_AXES; k++)
                    if (r_unb[k] < r_unb[j] || (r_unb[k] == r_unb[j] && k < j))
                        w = w + 1'b1;
                r_wgt[j] <= w + 1'b1;
            end
        end
        if (r_state == S_PRIO) begin
            // shift in so entry i ends up holding cell i
            for (int i = 0; i < NUM_CELLS - 1; i++) begin
                r_prio[i] <= r_prio[i+1];
                r_pid[i]  <= r_pid[i+1];
            end
            r_prio[NUM_CELLS-1] <= cell_prio;
            r_pid[NUM_CELLS-1]  <= r_cnt;
        end
        if (r_state == S_RANK) begin
            // rotate: head entry is ranked against all others each cycle
            for (int i = 0; i < NUM_CELLS - 1; i++) begin
                r_prio[i] <= r_prio[i+1];
                r_pid[i]  <= r_pid[i+1];
            end
            r_prio[NUM_CELLS-1] <= r_prio[0];
            r_pid[NUM_CELLS-1]  <= r_pid[0];
            r_sym[r_pid[0]]           <= CELL_BITS'(NUM_CELLS - 1) - rank;
            r_cell[CELL_BITS'(NUM_CELLS - 1) - rank] <= r_pid[0];
        end

        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cnt          <= '0;
            r_quant_bits   <= CFG_BITS'(12);
            r_cur_quant_id <= '0;
            r_compress     <= 1'b1;
            for (int j = 0; j < NUM_AXES; j++) begin
                r_lo[j] <= '0;
                r_hi[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_QUANT_BITS:   r_quant_bits   <= i_cfg_data;
                    CFG_CUR_QUANT_ID: r_cur_quant_id <= i_cfg_data;
                    CFG_COMPRESS:     r_compress     <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_state == S_ACC) begin
                // saturating accumulate on the side each axis fell to
                for (int j = 0; j < NUM_AXES; j++) begin
                    logic [ADD_BITS-1:0] s;
                    s = ADD_BITS'(r_side[j] ? r_hi[j] : r_lo[j]) + ADD_BITS'(r_w);
                    if (s > SUM_MAX)
                        s = SUM_MAX;
                    if (r_side[j])
                        r_hi[j] <= SUM_BITS'(s);
                    else
                        r_lo[j] <= SUM_BITS'(s);
                end
            end
            if (r_state == S_PRIO && r_cnt == CELL_BITS'(NUM_CELLS - 1)) begin
                // priorities are captured; the run's sums start fresh
                for (int j = 0; j < NUM_AXES; j++) begin
                    r_lo[j] <= '0;
                    r_hi[j] <= '0;
                end
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_map_key   = r_cnt;
    assign o_map_value = r_compress ? r_sym[r_cnt] : r_cell[r_cnt];
    assign o_last_pair = (r_cnt == CELL_BITS'(NUM_CELLS - 1));

`ifndef SYNTHESIS
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while pairs pending");
    a_root_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_stat.done |-> (r_state == S_ROOT))
        else $error("root finished outside its wait state");
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !o_last_pair) |=> (o_out_valid && o_map_key == $past(o_map_key) + 1'b1))
        else $error("output pairs out of order");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last_pair) |=> !o_out_valid)
        else $error("output continued after last pair");
`endif

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the octree cell symbol ranker.
`timescale 1ns / 100ps

module tb_top;
    import ocsr_pkg::*;

    localparam int CB = 16;
    localparam int FB = 4;
    localparam logic [32:0] SUM_MAX = 33'h0_FFFF_FFFF;

    typedef struct packed {
        logic signed [CB-1:0] cx, cy, cz, nx, ny, nz, ox, oy, oz;
        logic conq, last;
    } t_nb_req;

    typedef struct packed {
        logic [2:0] key, value;
        logic       last;
    } t_map_pair;

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = CFG_QUANT_BITS;
    logic [CFG_BITS-1:0] i_cfg_data = '0;
    logic i_in_valid = 0, o_in_stall;
    logic signed [CB-1:0] i_center_x = 0, i_center_y = 0, i_center_z = 0;
    logic signed [CB-1:0] i_nb_x = 0, i_nb_y = 0, i_nb_z = 0;
    logic signed [CB-1:0] i_old_x = 0, i_old_y = 0, i_old_z = 0;
    logic i_conquered = 0, i_last_neighbour = 0;
    logic o_out_valid, i_out_stall = 0;
    logic [CELL_BITS-1:0] o_map_key, o_map_value;
    logic o_last_pair;

    octree_cell_symbol_ranker uut (.*);

    initial forever #4 i_clk = ~i_clk;

    // limit: far beyond the slowest legal run
    initial begin
        #30_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // predictor state, a private copy of the block's registers and sums
    logic [4:0] qbits = 5'd12, qid = 5'd0;
    logic       cmode = 1'b1;
    logic [31:0] sums [6] = '{default: 0};

    t_nb_req   pending_reqs[$];
    t_map_pair expected_pairs[$];
    int errors = 0;
    int gap_left = 0, burst_left = 0;
    int hold_off = 0;

    function automatic logic [20:0] isqrt_fixed(logic [35:0] s);
        logic [41:0] v;
        logic [41:0] root, rem, trial;
        v = 42'(s) << (2 * FB);
        root = 0; rem = 0;
        for (int p = 20; p >= 0; p--) begin
            rem = (rem << 2) | ((v >> (2 * p)) & 3);
            trial = (root << 2) | 1;
            root = root << 1;
            if (rem >= trial) begin
                rem -= trial;
                root |= 1;
            end
        end
        return root[20:0];
    endfunction

    // accumulate one neighbour; on the last one queue the eight map pairs
    task automatic rank_neighbour(t_nb_req r);
        logic signed [CB-1:0] ctr[3], nb[3];
        logic signed [CB:0] d;
        logic [35:0] sq;
        logic [20:0] nb_len;
        logic [6:0] level;
        logic [32:0] w, acc;
        logic [31:0] unb[3];
        logic [1:0] wt[3];
        logic [35:0] prio[8];
        int order[8];
        int map[8];
        int p;
        bit use_old;
        t_map_pair pr;
        use_old = r.conq && cmode;
        ctr = '{r.cx, r.cy, r.cz};
        if (use_old) nb = '{r.ox, r.oy, r.oz};
        else nb = '{r.nx, r.ny, r.nz};
        sq = 0;
        for (int j = 0; j < 3; j++) begin
            d = nb[j] - ctr[j];
            if (d < 0) d = -d;
            sq += 36'(d) * 36'(d);
        end
        nb_len = isqrt_fixed(sq);
        level = (qbits > qid) ? 7'(qbits - qid) : 7'd0;
        level += r.conq;
        w = 33'(level) * 33'(nb_len);
        for (int j = 0; j < 3; j++) begin
            p = 2 * j + ((nb[j] <= ctr[j]) ? 0 : 1);
            acc = 33'(sums[p]) + w;
            sums[p] = (acc > SUM_MAX) ? 32'hFFFF_FFFF : acc[31:0];
        end
        if (!r.last) return;
        for (int j = 0; j < 3; j++)
            unb[j] = (sums[2*j] >= sums[2*j+1]) ? sums[2*j] - sums[2*j+1]
                                                : sums[2*j+1] - sums[2*j];
        for (int j = 0; j < 3; j++) begin
            wt[j] = 1;
            for (int k = 0; k < 3; k++)
                if (unb[k] < unb[j] || (unb[k] == unb[j] && k < j)) wt[j]++;
        end
        for (int c = 0; c < 8; c++) begin
            prio[c] = 0;
            for (int j = 0; j < 3; j++)
                prio[c] += 36'(wt[j]) * 36'(sums[2*j + ((c >> j) & 1)]);
        end
        for (int c = 0; c < 8; c++) begin
            p = c;
            while (p > 0 && prio[order[p-1]] > prio[c]) begin
                order[p] = order[p-1];
                p--;
            end
            order[p] = c;
        end
        for (int k = 0; k < 8; k++)
            if (cmode) map[order[k]] = 7 - k;
            else map[7-k] = order[k];
        for (int k = 0; k < 8; k++) begin
            pr = '{3'(k), 3'(map[k]), k == 7};
            expected_pairs = {expected_pairs, pr};
        end
        sums = '{default: 0};
    endtask

    // driver: bursts and gaps; payload held while stalled
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                rank_neighbour(pending_reqs.pop_front());
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > (i_in_valid && !o_in_stall ? 0 : 0)
                             && pending_reqs.size() > 0) begin
                    i_in_valid <= 1'b1;
                    {i_center_x, i_center_y, i_center_z, i_nb_x, i_nb_y, i_nb_z,
                     i_old_x, i_old_y, i_old_z, i_conquered, i_last_neighbour}
                        <= pending_reqs[0];
                    if (burst_left > 0) burst_left <= burst_left - 1;
                    else begin
                        burst_left <= $urandom_range(0, 6);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 40);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_pairs.size() == 0) begin
                    $display("%0t: unexpected pair key=%0d value=%0d last=%0b",
                             $time, o_map_key, o_map_value, o_last_pair);
                    errors++;
                end else begin
                    t_map_pair e;
                    e = expected_pairs.pop_front();
                    if (e.key !== o_map_key) begin
                        $display("%0t: map_key expected %0d actual %0d", $time, e.key, o_map_key);
                        errors++;
                    end
                    if (e.value !== o_map_value) begin
                        $display("%0t: map_value expected %0d actual %0d",
                                 $time, e.value, o_map_value);
                        errors++;
                    end
                    if (e.last !== o_last_pair) begin
                        $display("%0t: last_pair expected %0b actual %0b",
                                 $time, e.last, o_last_pair);
                        errors++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    function automatic t_nb_req make_req(logic signed [CB-1:0] c[3], bit conq, bit last,
                                         bit extreme);
        t_nb_req r;
        logic signed [CB-1:0] v[6];
        for (int i = 0; i < 6; i++) begin
            case ($urandom_range(0, extreme ? 4 : 9))
                0: v[i] = 16'sh7FFF;
                1: v[i] = -16'sh8000;
                2: v[i] = c[i % 3];
                default: v[i] = c[i % 3] + $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
            endcase
            if ($urandom_range(0, 5) == 0) v[i] = 16'($urandom);
        end
        r = '{c[0], c[1], c[2], v[0], v[1], v[2], v[3], v[4], v[5], conq, last};
        return r;
    endfunction

    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [4:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_QUANT_BITS:   qbits = val;
            CFG_CUR_QUANT_ID: qid = val;
            default:          cmode = val[0];
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || i_in_valid || expected_pairs.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic run_vertex(int n, bit extreme);
        logic signed [CB-1:0] c[3];
        for (int i = 0; i < 3; i++) c[i] = 16'($urandom);
        if (extreme) c = '{16'sh7FFF, -16'sh8000, 16'sd0};
        for (int i = 0; i < n; i++)
            pending_reqs = {pending_reqs,
                            make_req(c, $urandom_range(0, 1), i == n - 1, extreme)};
    endtask

    initial begin
        t_nb_req r;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: reset settings, single neighbour with all-equal sums, extremes
        r = '{default: 0};
        r.last = 1;
        pending_reqs = {pending_reqs, r};        // zero distance, all ties go low
        r = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, -16'sh8000,
              16'sh7FFF, -16'sh8000, 16'sh7FFF, 1'b1, 1'b0};
        pending_reqs = {pending_reqs, r};        // conquered, old position used: full span on y only
        r = '{-16'sh8000, -16'sh8000, -16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
              16'sh0, 16'sh0, 16'sh0, 1'b0, 1'b1};
        pending_reqs = {pending_reqs, r};
        run_vertex(4, 1);
        drain();
        // decompress, level floored at zero
        cfg_write(CFG_COMPRESS, 5'd0);
        cfg_write(CFG_CUR_QUANT_ID, 5'd16);
        cfg_write(CFG_QUANT_BITS, 5'd1);
        run_vertex(3, 1);
        drain();
        // top level with saturation pressure: many far neighbours
        cfg_write(CFG_QUANT_BITS, 5'd31);
        cfg_write(CFG_CUR_QUANT_ID, 5'd0);
        cfg_write(CFG_COMPRESS, 5'd1);
        run_vertex(12, 1);
        drain();
        // random phases, several settings
        for (int ph = 0; ph < 4; ph++) begin
            cfg_write(CFG_QUANT_BITS, 5'($urandom_range(1, 16)));
            cfg_write(CFG_CUR_QUANT_ID, 5'($urandom_range(0, 16)));
            cfg_write(CFG_COMPRESS, 5'($urandom_range(0, 1)));
            if (ph == 1) hold_off = 400;         // long receiver hold-off
            for (int v = 0; v < 8; v++) run_vertex($urandom_range(1, 7), 0);
            drain();
        end
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* files.f */
design/ocsr_pkg.sv
design/ocsr_isqrt.sv
design/octree_cell_symbol_ranker.sv
tb/tb_top.sv
